// File: rtl/core/cfa_pkg.sv
// Package for the contiguous frame allocator.
// Request kind codes, controller states and channel widths.
// No dependencies.
package cfa_pkg;

  // request kinds carried on in_tuser
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam int KIND_W  = 2;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;
  localparam int FIRST_W = 6;
  localparam int LEN_W   = 7;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 16;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_FREE,
    ST_QRD,
    ST_QDATA,
    ST_RESP
  } cfa_state_t;

endpackage

// File: rtl/core/contiguous_frame_allocator.sv
// First-fit contiguous frame allocator, top level.
// One occupancy bit per frame in a synchronous RAM, read-modify-write sequencer.
// Depends on cfa_pkg.
//
//   channel | handshake            | payload (lowest bit first)
//   --------+----------------------+------------------------------------------
//   in      | in_tvalid/in_tready  | tuser: kind; tdata: count, index
//   out     | out_tvalid/out_tready| tdata: status, first_frame, run_length,
//           |                      |        occupied
//
// Allocate: scan reads one frame per cycle from the map RAM until it finds a free run
// of count frames, then marks the run in the RAM and posts the result.
// Free: a RAM write per frame of the count. Query: a RAM read if the index is in range. Zero count: no RAM access.
// After reset a clearing pass writes every frame free, with in_tready low.
// One request at a time; a held result stalls only the next result, not acceptance.
module contiguous_frame_allocator #(
  parameter int FRAMES = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [cfa_pkg::IN_W-1:0] in_tdata,   // count[6:0], index[12:7]
  input  logic [cfa_pkg::KIND_W-1:0] in_tuser, // kind[1:0]
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [cfa_pkg::OUT_W-1:0] out_tdata  // status[0], first_frame[6:1],
                                               // run_length[13:7], occupied[14]
);
  import cfa_pkg::*;

  localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int PW = ((AW > COUNT_W) ? AW : COUNT_W) + 1;
  localparam logic [PW-1:0] FRAMES_P = PW'(FRAMES);

  cfa_state_t state_r, state_nxt;

  logic [PW-1:0]      pos_r, pos_nxt;
  logic [PW-1:0]      end_r, end_nxt;       // alloc: count during scan, run end in fill
  logic [PW-1:0]      start_r, start_nxt;
  logic [PW-1:0]      pend_pos_r, pend_pos_nxt;
  logic               pend_r, pend_nxt;
  logic [LEN_W-1:0]   run_r, run_nxt;
  logic               q_inrange_r, q_inrange_nxt;

  logic               res_status_r, res_status_nxt;
  logic [FIRST_W-1:0] res_first_r, res_first_nxt;
  logic [LEN_W-1:0]   res_len_r, res_len_nxt;
  logic               res_occ_r, res_occ_nxt;

  logic               out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]   out_tdata_r, out_tdata_nxt;

  logic               mem_we, mem_wd, mem_re;
  logic [AW-1:0]      mem_wa, mem_ra;
  logic               mem_q_r;
  logic               occ_mem [FRAMES];

  logic [KIND_W-1:0]  in_kind;
  logic [COUNT_W-1:0] in_count;
  logic [INDEX_W-1:0] in_index;
  logic               in_fire;
  logic               out_free;
  logic               scan_rd;
  logic [PW-1:0]      pos_inc;
  logic [LEN_W-1:0]   run_inc;
  logic [PW-1:0]      run_start;

  assign in_kind  = in_tuser;
  assign in_count = in_tdata[COUNT_W-1:0];
  assign in_index = in_tdata[COUNT_W +: INDEX_W];
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign scan_rd  = (state_r == ST_SCAN) && (pos_r < FRAMES_P);
  assign pos_inc  = pos_r + PW'(1);
  assign run_inc  = run_r + LEN_W'(1);
  assign run_start = (run_r == '0) ? pend_pos_r : start_r;

  // map RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= occ_mem[mem_ra];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        if (pos_inc == FRAMES_P) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_kind)
            KIND_ALLOC: state_nxt = (in_count == '0) ? ST_RESP : ST_SCAN;
            KIND_FREE:  state_nxt = (in_count == '0) ? ST_RESP : ST_FREE;
            KIND_QUERY: state_nxt = ST_QRD;
            default:    state_nxt = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        if (pend_r && !mem_q_r && (run_inc == end_r[LEN_W-1:0])) state_nxt = ST_FILL;
        else if (!pend_r && !scan_rd) state_nxt = ST_RESP;
      end
      ST_FILL: begin
        if (pos_inc == end_r) state_nxt = ST_RESP;
      end
      ST_FREE: begin
        if (pos_inc == end_r) state_nxt = ST_RESP;
      end
      ST_QRD:   state_nxt = ST_QDATA;
      ST_QDATA: state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    pos_nxt        = pos_r;
    end_nxt        = end_r;
    start_nxt      = start_r;
    pend_nxt       = 1'b0;
    pend_pos_nxt   = pos_r;
    run_nxt        = run_r;
    q_inrange_nxt  = q_inrange_r;
    res_status_nxt = res_status_r;
    res_first_nxt  = res_first_r;
    res_len_nxt    = res_len_r;
    res_occ_nxt    = res_occ_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    unique case (state_r)
      ST_CLR: begin
        pos_nxt = (pos_inc == FRAMES_P) ? '0 : pos_inc;
      end
      ST_IDLE: begin
        res_status_nxt = 1'b0;
        res_first_nxt  = '0;
        res_len_nxt    = '0;
        res_occ_nxt    = 1'b0;
        run_nxt        = '0;
        start_nxt      = '0;
        if (in_kind == KIND_ALLOC) begin
          pos_nxt = '0;
          end_nxt = PW'(in_count);
        end else begin
          pos_nxt = PW'(in_index);
          end_nxt = PW'(in_index) + PW'(in_count);
        end
        q_inrange_nxt = PW'(in_index) < FRAMES_P;
      end
      ST_SCAN: begin
        if (scan_rd) begin
          pos_nxt  = pos_inc;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (!mem_q_r) begin
            start_nxt = run_start;
            run_nxt   = run_inc;
            if (run_inc == end_r[LEN_W-1:0]) begin
              // run found: switch to marking it
              pend_nxt      = 1'b0;
              pos_nxt       = run_start;
              end_nxt       = run_start + end_r;
              res_first_nxt = run_start[FIRST_W-1:0];
              res_len_nxt   = end_r[LEN_W-1:0];
            end
          end else begin
            run_nxt = '0;
          end
        end else if (!scan_rd) begin
          res_status_nxt = 1'b1;
        end
      end
      ST_FILL, ST_FREE: begin
        pos_nxt = pos_inc;
      end
      ST_QDATA: begin
        res_occ_nxt = q_inrange_r && mem_q_r;
      end
      ST_RESP: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {1'b0, res_occ_r, res_len_r, res_first_r, res_status_r};
        end
      end
      default: begin
      end
    endcase
  end

  // outputs and RAM controls
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    mem_we    = 1'b0;
    mem_wd    = 1'b0;
    mem_wa    = pos_r[AW-1:0];
    mem_re    = 1'b0;
    mem_ra    = pos_r[AW-1:0];
    unique case (state_r)
      ST_CLR:  mem_we = 1'b1;
      ST_SCAN: mem_re = scan_rd;
      ST_FILL: begin
        mem_we = 1'b1;
        mem_wd = 1'b1;
      end
      ST_FREE: mem_we = (pos_r < FRAMES_P);   // frames past the store are ignored
      ST_QRD:  mem_re = q_inrange_r;
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      pos_r        <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r        <= end_nxt;
    start_r      <= start_nxt;
    pend_pos_r   <= pend_pos_nxt;
    run_r        <= run_nxt;
    q_inrange_r  <= q_inrange_nxt;
    res_status_r <= res_status_nxt;
    res_first_r  <= res_first_nxt;
    res_len_r    <= res_len_nxt;
    res_occ_r    <= res_occ_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

`ifndef SYNTH
  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (pos_r < FRAMES_P))
    else $error("fill write outside the frame store");

  a_run_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (PW'(run_r) < end_r))
    else $error("scan run reached count without switching to fill");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[0]) |-> (out_tdata_r[14:1] == '0))
    else $error("failed allocation reported nonzero fields");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == ST_RESP))
    else $error("result posted outside response state");
`endif

endmodule
